/* rtl/palette_writer_with_shade_derivation_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the palette writer
// Shared property forms, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PALETTE_WRITER_WITH_SHADE_DERIVATION_UNIT_ASSERT_SVH
`define PALETTE_WRITER_WITH_SHADE_DERIVATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PWSD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwsd assertion failed");

// Next-cycle implication.
`define PWSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwsd assertion failed");

`endif

/* rtl/pwsd_pkg.sv */
// ----------------------------------------------------------------------------
// pwsd_pkg
// Types, codes and constants of the palette writer with shade derivation.
// ----------------------------------------------------------------------------
`default_nettype none

package pwsd_pkg;

	localparam int NUM_ENTRIES = 6;

	typedef logic [2:0]  idx_t;
	typedef logic [23:0] rgb_t;

	localparam idx_t IDX_ACCENT    = 3'd0;
	localparam idx_t IDX_GLOW      = 3'd1;
	localparam idx_t IDX_DIM       = 3'd2;
	localparam idx_t IDX_PRIMARY   = 3'd3;
	localparam idx_t IDX_SECONDARY = 3'd4;
	localparam idx_t IDX_ALERT     = 3'd5;

	// Reset colour of each entry, in entry order.
	localparam rgb_t DEFAULT_COLOUR [NUM_ENTRIES] = '{
		24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000
	};

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_HEX  = 2'd1;
	localparam logic [1:0] STAT_BAD_SLOT = 2'd2;

	// ASCII slot letters
	localparam logic [7:0] SLOT_ACCENT    = 8'h61;
	localparam logic [7:0] SLOT_GLOW      = 8'h67;
	localparam logic [7:0] SLOT_DIM       = 8'h64;
	localparam logic [7:0] SLOT_PRIMARY   = 8'h70;
	localparam logic [7:0] SLOT_SECONDARY = 8'h73;
	localparam logic [7:0] SLOT_ALERT     = 8'h65;

	// ASCII hex digit bounds
	localparam logic [7:0] CH_DIGIT_LO = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI = 8'h39;
	localparam logic [7:0] CH_LOWER_LO = 8'h61;
	localparam logic [7:0] CH_LOWER_HI = 8'h66;
	localparam logic [7:0] CH_UPPER_LO = 8'h41;
	localparam logic [7:0] CH_UPPER_HI = 8'h46;

	// One quotient bit per cycle, eight per channel, three channels.
	localparam logic [4:0] DIV_LAST_STEP = 5'd23;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_LOAD
	} st_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ACCENT,
		WR_ENTRY
	} wr_t;

	// {valid, nibble}; valid is low for anything that is not a hex digit.
	function automatic logic [4:0] hex_nib(input logic [7:0] ch);
		logic [4:0] res;
		case (ch) inside
			[CH_DIGIT_LO:CH_DIGIT_HI]: res = {1'b1, ch[3:0]};
			[CH_LOWER_LO:CH_LOWER_HI]: res = {1'b1, ch[3:0] + 4'd9};
			[CH_UPPER_LO:CH_UPPER_HI]: res = {1'b1, ch[3:0] + 4'd9};
			default:                   res = 5'd0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

/* rtl/palette_writer_with_shade_derivation_unit.sv */
// ----------------------------------------------------------------------------
// palette_writer_with_shade_derivation_unit
// Six-entry RGB888 palette with hex-text slot writes and accent shade
// derivation (dim and glow).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: op selects a
//   raw accent write (raw_red/green/blue) or a slot write from six ASCII hex
//   characters addressed by slot_code. Output channel (out_valid / out_stall)
//   returns exactly one result beat per command: status, dirty_mark and all
//   six palette colours as they stand after the command.
//   Flow: an accent write with a non-black colour goes from accept through
//   the bit-serial glow divider (one quotient bit per cycle over three
//   channels) and then a load state; every other command goes straight to
//   the load state. The next beat is taken the cycle after a result is loaded.
//   The block works on one command at a time; in_stall is high while it does.
//   A result waiting under out_stall does not block the next command; only
//   the load of the following result waits for the output register.
//   Reset: all palette entries return to their default colours, no result is
//   pending and the input is open.
//   Stall: while out_stall is high the result beat holds unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_writer_with_shade_derivation_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  slot_code,
	input  wire logic [7:0]  hex_char_0,
	input  wire logic [7:0]  hex_char_1,
	input  wire logic [7:0]  hex_char_2,
	input  wire logic [7:0]  hex_char_3,
	input  wire logic [7:0]  hex_char_4,
	input  wire logic [7:0]  hex_char_5,
	input  wire logic [7:0]  raw_red,
	input  wire logic [7:0]  raw_green,
	input  wire logic [7:0]  raw_blue,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic             dirty_mark,
	output logic [23:0]      accent_colour,
	output logic [23:0]      glow_colour,
	output logic [23:0]      dim_colour,
	output logic [23:0]      primary_text_colour,
	output logic [23:0]      secondary_text_colour,
	output logic [23:0]      alert_colour
);

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	pwsd_pkg::st_t st_q, st_d;
	logic          in_acc;
	logic          calc_en;
	logic          fire;
	logic          out_valid_q;

	// ------------------------------------------------------------------
	// Command decode on the input beat
	// ------------------------------------------------------------------
	logic [4:0]    nib_0, nib_1, nib_2, nib_3, nib_4, nib_5;
	logic          hex_ok;
	logic [7:0]    dec_r, dec_g, dec_b, dec_mx;
	pwsd_pkg::wr_t dec_kind;
	pwsd_pkg::idx_t dec_idx;
	logic [1:0]    dec_stat;

	// Held command
	logic [7:0]    red_q, green_q, blue_q, mx_q;
	pwsd_pkg::wr_t kind_q;
	pwsd_pkg::idx_t idx_q;
	logic [1:0]    stat_q;

	// Bit-serial divider
	logic [4:0]    step_q;
	logic [7:0]    rem_q, low_q;
	logic [23:0]   glow_q;
	logic [7:0]    div_c;
	logic [15:0]   div_num;
	logic          div_first;
	logic [7:0]    rem_src, low_src;
	logic [8:0]    trial, diff;
	logic          qbit;
	logic [7:0]    rem_d;

	// Palette
	pwsd_pkg::rgb_t pal_q [pwsd_pkg::NUM_ENTRIES];
	pwsd_pkg::rgb_t pal_d [pwsd_pkg::NUM_ENTRIES];

	// Character check: every one of the six must be a hex digit.
	assign nib_0  = pwsd_pkg::hex_nib(hex_char_0);
	assign nib_1  = pwsd_pkg::hex_nib(hex_char_1);
	assign nib_2  = pwsd_pkg::hex_nib(hex_char_2);
	assign nib_3  = pwsd_pkg::hex_nib(hex_char_3);
	assign nib_4  = pwsd_pkg::hex_nib(hex_char_4);
	assign nib_5  = pwsd_pkg::hex_nib(hex_char_5);
	assign hex_ok = nib_0[4] & nib_1[4] & nib_2[4] & nib_3[4] & nib_4[4] & nib_5[4];

	assign dec_r = op ? raw_red   : {nib_0[3:0], nib_1[3:0]};
	assign dec_g = op ? raw_green : {nib_2[3:0], nib_3[3:0]};
	assign dec_b = op ? raw_blue  : {nib_4[3:0], nib_5[3:0]};

	always_comb begin
		dec_mx = dec_r;
		if (dec_g > dec_mx) begin
			dec_mx = dec_g;
		end
		if (dec_b > dec_mx) begin
			dec_mx = dec_b;
		end
	end

	// Bad characters take priority over an unknown slot letter.
	always_comb begin
		dec_kind = pwsd_pkg::WR_NONE;
		dec_idx  = pwsd_pkg::IDX_ACCENT;
		dec_stat = pwsd_pkg::STAT_OK;
		if (op) begin
			dec_kind = pwsd_pkg::WR_ACCENT;
		end else if (!hex_ok) begin
			dec_stat = pwsd_pkg::STAT_BAD_HEX;
		end else begin
			case (slot_code)
				pwsd_pkg::SLOT_ACCENT: begin
					dec_kind = pwsd_pkg::WR_ACCENT;
				end
				pwsd_pkg::SLOT_GLOW: begin
					dec_kind = pwsd_pkg::WR_ENTRY;
					dec_idx  = pwsd_pkg::IDX_GLOW;
				end
				pwsd_pkg::SLOT_DIM: begin
					dec_kind = pwsd_pkg::WR_ENTRY;
					dec_idx  = pwsd_pkg::IDX_DIM;
				end
				pwsd_pkg::SLOT_PRIMARY: begin
					dec_kind = pwsd_pkg::WR_ENTRY;
					dec_idx  = pwsd_pkg::IDX_PRIMARY;
				end
				pwsd_pkg::SLOT_SECONDARY: begin
					dec_kind = pwsd_pkg::WR_ENTRY;
					dec_idx  = pwsd_pkg::IDX_SECONDARY;
				end
				pwsd_pkg::SLOT_ALERT: begin
					dec_kind = pwsd_pkg::WR_ENTRY;
					dec_idx  = pwsd_pkg::IDX_ALERT;
				end
				default: begin
					dec_stat = pwsd_pkg::STAT_BAD_SLOT;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// State machine
	// ------------------------------------------------------------------
	always_comb begin
		st_d = st_q;
		case (st_q)
			pwsd_pkg::ST_IDLE: begin
				if (in_valid) begin
					// A black accent needs no division: glow is black.
					if (dec_kind == pwsd_pkg::WR_ACCENT && dec_mx != 8'd0) begin
						st_d = pwsd_pkg::ST_CALC;
					end else begin
						st_d = pwsd_pkg::ST_LOAD;
					end
				end
			end
			pwsd_pkg::ST_CALC: begin
				if (step_q == pwsd_pkg::DIV_LAST_STEP) begin
					st_d = pwsd_pkg::ST_LOAD;
				end
			end
			pwsd_pkg::ST_LOAD: begin
				if (!out_valid_q || !out_stall) begin
					st_d = pwsd_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = pwsd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		calc_en  = 1'b0;
		fire     = 1'b0;
		case (st_q)
			pwsd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			pwsd_pkg::ST_CALC: begin
				calc_en = 1'b1;
			end
			pwsd_pkg::ST_LOAD: begin
				fire = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pwsd_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Capture the decoded command.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			red_q   <= dec_r;
			green_q <= dec_g;
			blue_q  <= dec_b;
			mx_q    <= dec_mx;
			kind_q  <= dec_kind;
			idx_q   <= dec_idx;
			stat_q  <= dec_stat;
		end
	end

	// ------------------------------------------------------------------
	// Glow divider: (c*255 + mx/2) / mx, restoring, one quotient bit per
	// cycle. Step bits [4:3] pick the channel, [2:0] the bit within it.
	// Since c <= mx the quotient fits in eight bits, so the upper dividend
	// byte already sits below mx and eight steps finish the channel.
	// ------------------------------------------------------------------
	always_comb begin
		case (step_q[4:3])
			2'd0:    div_c = red_q;
			2'd1:    div_c = green_q;
			default: div_c = blue_q;
		endcase
	end

	assign div_num   = {div_c, 8'h00} - {8'h00, div_c} + {9'h000, mx_q[7:1]};
	assign div_first = (step_q[2:0] == 3'd0);
	assign rem_src   = div_first ? div_num[15:8] : rem_q;
	assign low_src   = div_first ? div_num[7:0]  : low_q;
	assign trial     = {rem_src, low_src[7]};
	assign diff      = trial - {1'b0, mx_q};
	assign qbit      = (trial >= {1'b0, mx_q});
	assign rem_d     = qbit ? diff[7:0] : trial[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 5'd0;
		end else if (in_acc) begin
			step_q <= 5'd0;
		end else if (calc_en) begin
			step_q <= step_q + 5'd1;
		end
	end

	// Shift the dividend out and the quotient in, MSB first.
	always_ff @(posedge clk) begin
		if (calc_en) begin
			rem_q  <= rem_d;
			low_q  <= {low_src[6:0], 1'b0};
			glow_q <= {glow_q[22:0], qbit};
		end
	end

	// ------------------------------------------------------------------
	// Palette update, committed together with the result load
	// ------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < pwsd_pkg::NUM_ENTRIES; i++) begin
			pal_d[i] = pal_q[i];
		end
		if (fire) begin
			case (kind_q)
				pwsd_pkg::WR_ACCENT: begin
					pal_d[pwsd_pkg::IDX_ACCENT] = {red_q, green_q, blue_q};
					pal_d[pwsd_pkg::IDX_DIM]    = {2'b00, red_q[7:2], 2'b00, green_q[7:2],
						2'b00, blue_q[7:2]};
					pal_d[pwsd_pkg::IDX_GLOW]   = (mx_q == 8'd0) ? 24'h000000 : glow_q;
				end
				pwsd_pkg::WR_ENTRY: begin
					pal_d[idx_q] = {red_q, green_q, blue_q};
				end
				default: begin
					pal_d[pwsd_pkg::IDX_ACCENT] = pal_q[pwsd_pkg::IDX_ACCENT];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pwsd_pkg::NUM_ENTRIES; i++) begin
				pal_q[i] <= pwsd_pkg::DEFAULT_COLOUR[i];
			end
		end else begin
			for (int i = 0; i < pwsd_pkg::NUM_ENTRIES; i++) begin
				pal_q[i] <= pal_d[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold the beat while stalled, drop valid once taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status                <= stat_q;
			dirty_mark            <= (kind_q != pwsd_pkg::WR_NONE);
			accent_colour         <= pal_d[pwsd_pkg::IDX_ACCENT];
			glow_colour           <= pal_d[pwsd_pkg::IDX_GLOW];
			dim_colour            <= pal_d[pwsd_pkg::IDX_DIM];
			primary_text_colour   <= pal_d[pwsd_pkg::IDX_PRIMARY];
			secondary_text_colour <= pal_d[pwsd_pkg::IDX_SECONDARY];
			alert_colour          <= pal_d[pwsd_pkg::IDX_ALERT];
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/pwsd_checker.sv */
// ----------------------------------------------------------------------------
// pwsd_checker
// Port-level checks of the palette writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "palette_writer_with_shade_derivation_unit_assert.svh"

module pwsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic        dirty_mark,
	input wire logic [23:0] accent_colour,
	input wire logic [23:0] glow_colour,
	input wire logic [23:0] dim_colour
);

	// A stalled result beat stays valid and unchanged.
	`PWSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(dirty_mark) && $stable(accent_colour) && $stable(glow_colour) && $stable(dim_colour))

	// Only an accepted command marks the palette dirty.
	`PWSD_ASSERT_NOW(a_dirty_ok, out_valid && dirty_mark, status == pwsd_pkg::STAT_OK)

	// Status carries one of the three defined codes.
	`PWSD_ASSERT_NOW(a_stat_code, out_valid, status == pwsd_pkg::STAT_OK || status == pwsd_pkg::STAT_BAD_HEX || status == pwsd_pkg::STAT_BAD_SLOT)

	// One command in flight: the input closes right after a beat is taken.
	`PWSD_ASSERT_NEXT(a_one_cmd, in_valid && !in_stall, in_stall)

endmodule

bind palette_writer_with_shade_derivation_unit pwsd_checker u_pwsd_checker (.*);

`default_nettype wire

/* tb/pwsd_palette_checker.sv */
// ----------------------------------------------------------------------------
// pwsd_palette_checker
// Watches both channels of the palette writer, keeps a shadow palette that
// is updated for every accepted command beat, and compares each result beat
// field by field against the oldest predicted palette view.
// ----------------------------------------------------------------------------
module pwsd_palette_checker import pwsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [7:0]  slot_code,
	input  logic [7:0]  hex_char_0,
	input  logic [7:0]  hex_char_1,
	input  logic [7:0]  hex_char_2,
	input  logic [7:0]  hex_char_3,
	input  logic [7:0]  hex_char_4,
	input  logic [7:0]  hex_char_5,
	input  logic [7:0]  raw_red,
	input  logic [7:0]  raw_green,
	input  logic [7:0]  raw_blue,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic        dirty_mark,
	input  logic [23:0] accent_colour,
	input  logic [23:0] glow_colour,
	input  logic [23:0] dim_colour,
	input  logic [23:0] primary_text_colour,
	input  logic [23:0] secondary_text_colour,
	input  logic [23:0] alert_colour,
	output int          fail_count,
	output int          pending_results
);

	typedef struct packed {
		logic [1:0] status;
		logic       dirty;
		rgb_t       accent;
		rgb_t       glow;
		rgb_t       dim;
		rgb_t       primary;
		rgb_t       secondary;
		rgb_t       alert;
	} palette_view_t;

	rgb_t          palette_shadow [NUM_ENTRIES];
	palette_view_t expected_views [$];
	palette_view_t want;
	int            mismatches = 0;

	initial begin
		for (int k = 0; k < NUM_ENTRIES; k++)
			palette_shadow[k] = DEFAULT_COLOUR[k];
		fail_count = 0;
		pending_results = 0;
	end

	// {ok, nibble}; ok is low for anything but an ASCII hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] ch);
		logic [7:0] offs;
		offs = 8'd0;
		if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) begin
			offs = ch - CH_DIGIT_LO;
			return {1'b1, offs[3:0]};
		end
		if (ch >= CH_LOWER_LO && ch <= CH_LOWER_HI) begin
			offs = ch - CH_LOWER_LO + 8'd10;
			return {1'b1, offs[3:0]};
		end
		if (ch >= CH_UPPER_LO && ch <= CH_UPPER_HI) begin
			offs = ch - CH_UPPER_LO + 8'd10;
			return {1'b1, offs[3:0]};
		end
		return 5'd0;
	endfunction

	// Rounded c * 255 / peak
	function automatic logic [7:0] stretch_channel(input logic [7:0] c, input logic [7:0] peak);
		logic [15:0] num;
		logic [15:0] quo;
		num = {8'd0, c} * 16'd255 + {9'd0, peak[7:1]};
		quo = num / {8'd0, peak};
		return quo[7:0];
	endfunction

	function automatic void load_accent(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [7:0] peak;
		peak = r;
		if (g > peak) peak = g;
		if (b > peak) peak = b;
		palette_shadow[IDX_ACCENT] = {r, g, b};
		palette_shadow[IDX_DIM]    = {2'b00, r[7:2], 2'b00, g[7:2], 2'b00, b[7:2]};
		if (peak == 8'd0)
			palette_shadow[IDX_GLOW] = 24'd0;
		else
			palette_shadow[IDX_GLOW] = {stretch_channel(r, peak), stretch_channel(g, peak),
				stretch_channel(b, peak)};
	endfunction

	function automatic palette_view_t predict_palette_write(input logic cmd_op,
			input logic [7:0] slot, input logic [47:0] text, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		palette_view_t v;
		logic [4:0]    dig;
		logic [23:0]   colour;
		logic          text_ok;
		v = '0;
		text_ok = 1'b1;
		colour = 24'd0;
		if (cmd_op) begin
			load_accent(r, g, b);
			v.dirty = 1'b1;
		end else begin
			for (int k = 0; k < 6; k++) begin
				dig = hex_digit(text[47 - 8 * k -: 8]);
				if (!dig[4]) text_ok = 1'b0;
				colour[23 - 4 * k -: 4] = dig[3:0];
			end
			if (!text_ok) begin
				// a bad character wins over a bad slot
				v.status = STAT_BAD_HEX;
			end else begin
				v.dirty = 1'b1;
				case (slot)
					SLOT_ACCENT:    load_accent(colour[23:16], colour[15:8], colour[7:0]);
					SLOT_GLOW:      palette_shadow[IDX_GLOW] = colour;
					SLOT_DIM:       palette_shadow[IDX_DIM] = colour;
					SLOT_PRIMARY:   palette_shadow[IDX_PRIMARY] = colour;
					SLOT_SECONDARY: palette_shadow[IDX_SECONDARY] = colour;
					SLOT_ALERT:     palette_shadow[IDX_ALERT] = colour;
					default: begin
						v.status = STAT_BAD_SLOT;
						v.dirty = 1'b0;
					end
				endcase
			end
		end
		v.accent    = palette_shadow[IDX_ACCENT];
		v.glow      = palette_shadow[IDX_GLOW];
		v.dim       = palette_shadow[IDX_DIM];
		v.primary   = palette_shadow[IDX_PRIMARY];
		v.secondary = palette_shadow[IDX_SECONDARY];
		v.alert     = palette_shadow[IDX_ALERT];
		return v;
	endfunction

	function automatic int field_differs(input string name, input logic [23:0] exp_val,
			input logic [23:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %h, got %h", name, exp_val, got_val);
			return 1;
		end
		return 0;
	endfunction

	// Check the result beat first: a command taken on this edge cannot own it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_views.size() == 0) begin
					$error("result beat with no command outstanding");
					mismatches++;
				end else begin
					want = expected_views.pop_front();
					mismatches += field_differs("status", {22'd0, want.status}, {22'd0, status});
					mismatches += field_differs("dirty_mark", {23'd0, want.dirty},
						{23'd0, dirty_mark});
					mismatches += field_differs("accent_colour", want.accent, accent_colour);
					mismatches += field_differs("glow_colour", want.glow, glow_colour);
					mismatches += field_differs("dim_colour", want.dim, dim_colour);
					mismatches += field_differs("primary_text_colour", want.primary,
						primary_text_colour);
					mismatches += field_differs("secondary_text_colour", want.secondary,
						secondary_text_colour);
					mismatches += field_differs("alert_colour", want.alert, alert_colour);
				end
			end
			if (in_valid && !in_stall)
				expected_views.push_back(predict_palette_write(op, slot_code,
					{hex_char_0, hex_char_1, hex_char_2, hex_char_3, hex_char_4, hex_char_5},
					raw_red, raw_green, raw_blue));
			fail_count <= mismatches;
			pending_results <= expected_views.size();
		end
	end

endmodule

/* tb/palette_writer_with_shade_derivation_unit_tb.sv */
// ----------------------------------------------------------------------------
// palette_writer_with_shade_derivation_unit_tb
// Drives raw accent writes and hex-text slot writes into the palette writer,
// first a directed set of corner cases, then a long random mix of good and
// broken commands, with random gaps on the input and random stalls on the
// output. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module palette_writer_with_shade_derivation_unit_tb;

	import pwsd_pkg::*;

	localparam int RANDOM_BEATS = 1525;

	// One command beat, hex text packed with the first character on top
	typedef struct packed {
		logic        op;
		logic [7:0]  slot;
		logic [47:0] text;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} palette_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [7:0]  slot_code = 8'd0;
	logic [7:0]  hex_char_0 = 8'd0;
	logic [7:0]  hex_char_1 = 8'd0;
	logic [7:0]  hex_char_2 = 8'd0;
	logic [7:0]  hex_char_3 = 8'd0;
	logic [7:0]  hex_char_4 = 8'd0;
	logic [7:0]  hex_char_5 = 8'd0;
	logic [7:0]  raw_red = 8'd0;
	logic [7:0]  raw_green = 8'd0;
	logic [7:0]  raw_blue = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        dirty_mark;
	logic [23:0] accent_colour;
	logic [23:0] glow_colour;
	logic [23:0] dim_colour;
	logic [23:0] primary_text_colour;
	logic [23:0] secondary_text_colour;
	logic [23:0] alert_colour;
	int          fail_count;
	int          pending_results;

	int           stall_run = 0;
	int           stall_roll;
	palette_cmd_t directed [$];

	palette_writer_with_shade_derivation_unit u_dut (.*);

	pwsd_palette_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("FAIL palette_writer_with_shade_derivation_unit");
		$finish;
	end

	// Output stall: mostly open, short stalls, rare long ones, and now and
	// then a long stretch with no stall at all
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_run > 0) begin
				stall_run <= stall_run - 1;
			end else begin
				stall_roll = $urandom_range(0, 99);
				if (stall_roll < 8) begin
					out_stall <= 1'b0;
					stall_run <= $urandom_range(100, 300);
				end else if (stall_roll < 60) begin
					out_stall <= 1'b0;
					stall_run <= $urandom_range(0, 8);
				end else if (stall_roll < 90) begin
					out_stall <= 1'b1;
					stall_run <= $urandom_range(0, 2);
				end else if (stall_roll < 98) begin
					out_stall <= 1'b1;
					stall_run <= $urandom_range(3, 11);
				end else begin
					out_stall <= 1'b1;
					stall_run <= $urandom_range(19, 59);
				end
			end
		end
	end

	function automatic logic [7:0] slot_letter(input int k);
		case (k)
			0:       return SLOT_ACCENT;
			1:       return SLOT_GLOW;
			2:       return SLOT_DIM;
			3:       return SLOT_PRIMARY;
			4:       return SLOT_SECONDARY;
			default: return SLOT_ALERT;
		endcase
	endfunction

	// Any of the 22 legal hex characters, either case
	function automatic logic [7:0] pick_hex_char();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10) return CH_DIGIT_LO + 8'(k);
		if (k < 16) return CH_LOWER_LO + 8'(k - 10);
		return CH_UPPER_LO + 8'(k - 16);
	endfunction

	function automatic palette_cmd_t raw_cmd(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		palette_cmd_t c;
		c = '0;
		c.op = 1'b1;
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	function automatic palette_cmd_t text_cmd(input logic [7:0] slot, input string s);
		palette_cmd_t c;
		c = '0;
		c.slot = slot;
		for (int k = 0; k < 6; k++)
			c.text[47 - 8 * k -: 8] = s[k];
		return c;
	endfunction

	// Mostly well-formed writes with random content; the rest are broken
	// text, unknown slots and raw writes with junk in the unused fields.
	function automatic palette_cmd_t random_command();
		palette_cmd_t c;
		int           roll;
		int           pos;
		c.op = ($urandom_range(0, 99) < 30);
		c.slot = 8'($urandom_range(0, 255));
		c.text[47:16] = $urandom;
		c.text[15:0] = 16'($urandom);
		c.red = 8'($urandom_range(0, 255));
		c.green = 8'($urandom_range(0, 255));
		c.blue = 8'($urandom_range(0, 255));
		if (c.op) begin
			roll = $urandom_range(0, 99);
			// small channels stress the glow rounding, zeros hit black
			if (roll < 20) begin
				c.red = 8'($urandom_range(0, 3));
				c.green = 8'($urandom_range(0, 3));
				c.blue = 8'($urandom_range(0, 3));
			end else if (roll < 25) begin
				c.red = 8'd0;
				c.green = 8'd0;
				c.blue = 8'd0;
			end
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 75)
				c.slot = slot_letter($urandom_range(0, 5));
			else if (roll < 85)
				c.slot = slot_letter($urandom_range(0, 5)) - 8'h20;
			for (int k = 0; k < 6; k++)
				c.text[47 - 8 * k -: 8] = pick_hex_char();
			roll = $urandom_range(0, 99);
			if (roll >= 85) begin
				pos = $urandom_range(0, 5);
				c.text[47 - 8 * pos -: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 :
					8'($urandom_range(0, 255));
			end
		end
		return c;
	endfunction

	// Present one beat and hold it until the block takes it
	task automatic send_beat(input palette_cmd_t cmd);
		op <= cmd.op;
		slot_code <= cmd.slot;
		hex_char_0 <= cmd.text[47:40];
		hex_char_1 <= cmd.text[39:32];
		hex_char_2 <= cmd.text[31:24];
		hex_char_3 <= cmd.text[23:16];
		hex_char_4 <= cmd.text[15:8];
		hex_char_5 <= cmd.text[7:0];
		raw_red <= cmd.red;
		raw_green <= cmd.green;
		raw_blue <= cmd.blue;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid for a random gap, or keep it up for a back-to-back beat.
	// Every fourth run of 200 beats goes without gaps.
	task automatic pause_input(input int beat_no);
		int gap;
		int roll;
		roll = $urandom_range(0, 99);
		if ((beat_no / 200) % 4 == 2 || roll < 50)
			gap = 0;
		else if (roll < 85)
			gap = $urandom_range(1, 3);
		else if (roll < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		palette_cmd_t c;

		// Raw accent writes: black, white, saturated, tiny channels for rounding
		directed.push_back(raw_cmd(8'h00, 8'h00, 8'h00));
		directed.push_back(raw_cmd(8'hff, 8'hff, 8'hff));
		directed.push_back(raw_cmd(8'hff, 8'h00, 8'h80));
		directed.push_back(raw_cmd(8'h01, 8'h02, 8'h03));
		directed.push_back(raw_cmd(8'h03, 8'h00, 8'h01));
		// Raw write ignores slot and text, even when both are junk
		c = raw_cmd(8'h80, 8'h40, 8'h7f);
		c.slot = 8'hff;
		c.text = '1;
		directed.push_back(c);
		// Every slot from hex text, mixed case
		directed.push_back(text_cmd(SLOT_ACCENT, "1A2b3C"));
		directed.push_back(text_cmd(SLOT_GLOW, "ffffff"));
		directed.push_back(text_cmd(SLOT_DIM, "000000"));
		directed.push_back(text_cmd(SLOT_PRIMARY, "09afAF"));
		directed.push_back(text_cmd(SLOT_SECONDARY, "FEDCBA"));
		directed.push_back(text_cmd(SLOT_ALERT, "123456"));
		directed.push_back(text_cmd(SLOT_ACCENT, "000000"));
		// Bad characters just outside each legal range, at different positions
		directed.push_back(text_cmd(SLOT_PRIMARY, "G00000"));
		directed.push_back(text_cmd(SLOT_PRIMARY, "12/456"));
		directed.push_back(text_cmd(SLOT_PRIMARY, "1234:6"));
		directed.push_back(text_cmd(SLOT_SECONDARY, "@ABCDE"));
		directed.push_back(text_cmd(SLOT_ALERT, "`abcde"));
		directed.push_back(text_cmd(SLOT_ALERT, "abcdeg"));
		// NUL in the last position
		c = text_cmd(SLOT_GLOW, "123456");
		c.text[7:0] = 8'h00;
		directed.push_back(c);
		// Bad text together with an unknown slot reports the text
		directed.push_back(text_cmd(8'h58, "zz0000"));
		// Unknown slots: uppercase letter, the two byte extremes
		directed.push_back(text_cmd(SLOT_ACCENT - 8'h20, "123456"));
		directed.push_back(text_cmd(8'h00, "abcdef"));
		directed.push_back(text_cmd(8'hff, "ABCDEF"));
		// Raw black accent after the black text accent; glow stays black
		directed.push_back(raw_cmd(8'h00, 8'h00, 8'h00));

		// Hold reset, then release it on a clock edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			send_beat(directed[k]);
			pause_input(k);
		end
		for (int k = 0; k < RANDOM_BEATS; k++) begin
			send_beat(random_command());
			pause_input(k);
		end
		in_valid <= 1'b0;

		// Let the last push land, drain all results, then idle past the latency
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("PASS palette_writer_with_shade_derivation_unit");
		else
			$display("FAIL palette_writer_with_shade_derivation_unit");
		$finish;
	end

endmodule
